### src/field_intensity_max_pool_2x2_defines.svh
// Assertion macros for the 2x2 intensity max pool checker
`ifndef FIELD_INTENSITY_MAX_POOL_2X2_DEFINES_SVH
`define FIELD_INTENSITY_MAX_POOL_2X2_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define FIMP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define FIMP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/fimp_pkg.sv
// Shared constants and controller/datapath types for the 2x2 intensity max pool
package fimp_pkg;

   localparam int GRID_SIZE = 256;
   localparam int PAIRS     = GRID_SIZE / 2;
   localparam int CNT_W     = $clog2(GRID_SIZE);
   localparam int PAIR_W    = CNT_W - 1;

   localparam logic [CNT_W:0]    PAIR_SPAN = (CNT_W + 1)'(2 * PAIRS);
   localparam logic [CNT_W-1:0]  GRID_LAST = CNT_W'(GRID_SIZE - 1);
   localparam logic [CNT_W-1:0]  LAST_ROW  = CNT_W'(2 * PAIRS - 1);
   localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(PAIRS - 1);

   localparam int GAIN_W    = 16;
   localparam int PEAK_W    = 32;
   localparam int PROD_W    = 48;
   localparam int GAIN_SHIFT = 12;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
   localparam logic [PROD_W:0]   ROUND_HALF = 49'd2048;

   typedef struct packed {
      logic accept;
      logic sq_re;
      logic sq_im;
      logic scale;
      logic round;
      logic pool;
   } fimp_cmd_type;

   typedef struct packed {
      logic out_hold;
   } fimp_status_type;

endpackage

### src/fimp_ram.sv
// Generic single-port-write, registered-read RAM
module fimp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_en,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         store_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= store_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

### src/fimp_ctrl.sv
// Sequencer for the 2x2 intensity max pool: steps one item through the datapath
module fimp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  fimp_pkg::fimp_status_type status,
   output fimp_pkg::fimp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SQ_RE,
      SQ_IM,
      SCALE,
      ROUND,
      POOL
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               state_in = SQ_RE;
            end
         end
         SQ_RE: begin
            cmd.sq_re = 1'b1;
            state_in  = SQ_IM;
         end
         SQ_IM: begin
            cmd.sq_im = 1'b1;
            state_in  = SCALE;
         end
         SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ROUND;
         end
         ROUND: begin
            cmd.round = 1'b1;
            state_in  = POOL;
         end
         POOL: begin
            if (!status.out_hold) begin
               cmd.pool = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == IDLE);

endmodule

### src/fimp_datapath.sv
// Datapath: intensity, gain, round/saturate, pair max, line store and output register
module fimp_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  fimp_pkg::fimp_cmd_type     cmd,
   output fimp_pkg::fimp_status_type  status,
   input  logic [31:0]               req_tdata,
   input  logic                      csr_valid,
   input  logic [15:0]               csr_wdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,
   output logic                      rsp_tlast
);

   logic [fimp_pkg::GAIN_W-1:0]  gain_ff;
   logic [fimp_pkg::CNT_W-1:0]   col_ff;
   logic [fimp_pkg::CNT_W-1:0]   row_ff;
   logic [fimp_pkg::CNT_W-1:0]   col_in;
   logic [fimp_pkg::CNT_W-1:0]   row_in;

   logic signed [15:0]           re_ff;
   logic signed [15:0]           im_ff;
   logic                         odd_col_ff;
   logic                         odd_row_ff;
   logic                         in_range_ff;
   logic                         last_ff;
   logic [fimp_pkg::PAIR_W-1:0]  pair_ff;

   logic signed [31:0]           re_sq;
   logic signed [31:0]           im_sq;
   logic [30:0]                  sq_ff;
   logic [31:0]                  pwr_ff;
   logic [fimp_pkg::PROD_W-1:0]  prod_ff;
   logic [fimp_pkg::PROD_W:0]    rounded;
   logic [fimp_pkg::PEAK_W-1:0]  val_ff;
   logic [fimp_pkg::PEAK_W-1:0]  val_in;

   logic [fimp_pkg::PEAK_W-1:0]  pair_peak_ff;
   logic [fimp_pkg::PEAK_W-1:0]  pair_max;
   logic [fimp_pkg::PEAK_W-1:0]  store_rd;
   logic [fimp_pkg::PEAK_W-1:0]  block_max;
   logic                         emit;
   logic                         store_we;

   logic                         rsp_valid_ff;
   logic [fimp_pkg::PEAK_W-1:0]  rsp_peak_ff;
   logic                         rsp_last_ff;

   // raster position of the next item
   always_comb begin
      col_in = col_ff + 1'b1;
      row_in = row_ff;
      if (col_ff == fimp_pkg::GRID_LAST) begin
         col_in = '0;
         row_in = (row_ff == fimp_pkg::GRID_LAST) ? '0 : row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= fimp_pkg::GAIN_RESET;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         if (csr_valid) begin
            gain_ff <= csr_wdata;
         end
         if (cmd.accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         re_ff       <= req_tdata[15:0];
         im_ff       <= req_tdata[31:16];
         odd_col_ff  <= col_ff[0];
         odd_row_ff  <= row_ff[0];
         in_range_ff <= ({1'b0, col_ff} < fimp_pkg::PAIR_SPAN) &&
                        ({1'b0, row_ff} < fimp_pkg::PAIR_SPAN);
         pair_ff     <= col_ff[fimp_pkg::CNT_W-1:1];
         last_ff     <= (col_ff[fimp_pkg::CNT_W-1:1] == fimp_pkg::LAST_PAIR) &&
                        (row_ff == fimp_pkg::LAST_ROW);
      end
   end

   assign re_sq = re_ff * re_ff;
   assign im_sq = im_ff * im_ff;

   // round half up, then clamp to 32 bits
   assign rounded = {1'b0, prod_ff} + fimp_pkg::ROUND_HALF;
   assign val_in  = (|rounded[fimp_pkg::PROD_W:fimp_pkg::PEAK_W+fimp_pkg::GAIN_SHIFT]) ?
                    '1 :
                    rounded[fimp_pkg::PEAK_W+fimp_pkg::GAIN_SHIFT-1:fimp_pkg::GAIN_SHIFT];

   always_ff @(posedge clock) begin
      if (cmd.sq_re) begin
         sq_ff <= re_sq[30:0];
      end
      if (cmd.sq_im) begin
         pwr_ff <= {1'b0, sq_ff} + {1'b0, im_sq[30:0]};
      end
      if (cmd.scale) begin
         prod_ff <= fimp_pkg::PROD_W'(pwr_ff) * fimp_pkg::PROD_W'(gain_ff);
      end
      if (cmd.round) begin
         val_ff <= val_in;
      end
   end

   assign pair_max  = (pair_peak_ff > val_ff) ? pair_peak_ff : val_ff;
   assign block_max = (store_rd > pair_max) ? store_rd : pair_max;
   assign emit      = in_range_ff && odd_col_ff && odd_row_ff;
   assign store_we  = cmd.pool && in_range_ff && odd_col_ff && !odd_row_ff;

   fimp_ram #(
      .WIDTH (fimp_pkg::PEAK_W),
      .DEPTH (fimp_pkg::PAIRS)
   ) u_line_store (
      .clock      (clock),
      .write_en   (store_we),
      .write_addr (pair_ff),
      .write_data (pair_max),
      .read_en    (cmd.sq_re),
      .read_addr  (pair_ff),
      .read_data  (store_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_peak_ff <= '0;
      end else if (cmd.pool && in_range_ff && !odd_col_ff) begin
         pair_peak_ff <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.pool && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pool && emit) begin
         rsp_peak_ff <= block_max;
         rsp_last_ff <= last_ff;
      end
   end

   assign status.out_hold = emit && rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_peak_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### src/field_intensity_max_pool_2x2.sv
// Top level of the 2x2 max pool over scaled field intensity
// Each item passes through accept, re^2, +im^2, gain multiply, round/saturate and pool in turn.
// A new item is taken only after the last one leaves pool, as the square/scale sequence is shared.
// A pooled result is registered in the pool step of the odd-row, odd-column item.
// Synchronous reset clears position counters and output valid; gain returns to 1.0.
// The line store is not cleared: each entry is written on an even row before it is read.
module field_intensity_max_pool_2x2 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] field_real, [31:16] field_imag
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] pooled_peak
   output logic        rsp_tlast,   // frame_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata    // [15:0] intensity_gain
);

   fimp_pkg::fimp_cmd_type    cmd;
   fimp_pkg::fimp_status_type status;

   assign csr_ready = 1'b1;

   fimp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fimp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### src/fimp_checker.sv
// Port-level checker for the 2x2 intensity max pool, bound to the top level
`include "field_intensity_max_pool_2x2_defines.svh"

module fimp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic        req_take;
   logic        rsp_stall;
   logic [32:0] rsp_word;

   assign req_take  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tlast, rsp_tdata};

   `FIMP_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word), "stalled result changed")
   `FIMP_ASSERT_NEXT(a_busy_after_accept, req_take, !req_tready, "new item taken while busy")
   `FIMP_ASSERT_SAME(a_rsp_after_work, $rose(rsp_tvalid), $past(!req_tready), "stray result")

endmodule

bind field_intensity_max_pool_2x2 fimp_checker u_fimp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
